// ----- rtl/psa_pkg.sv -----
`default_nettype none

package psa_pkg;

  localparam int unsigned WAIT_W = 5;
  localparam logic [7:0]  CAP_RESET = 8'd1;

  // Request field values
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] priority_req;
    logic [7:0]         requester_tag;
  } psa_in_t;

  typedef struct packed {
    logic              grant_valid;
    logic [7:0]        grant_tag;
    logic              queued;
    logic              rejected;
    logic              release_ignored;
    logic [7:0]        busy_count;
    logic [WAIT_W-1:0] waiting_count;
  } psa_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } psa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic grant_now;
    logic enqueue;
    logic reject;
    logic grant_head;
    logic slot_dec;
    logic ignore;
  } psa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_release;
    logic slot_free;
    logic q_full;
    logic q_empty;
    logic none_busy;
  } psa_stat_t;

endpackage

`default_nettype wire

// ----- rtl/psa_ctrl.sv -----
`default_nettype none

module psa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire psa_pkg::psa_stat_t stat,
  output psa_pkg::psa_cmd_t       cmd,
  output logic                    busy
);
  import psa_pkg::*;

  psa_state_t state_r;
  psa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = start;
      end
      ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
        // pick exactly one action from the latched transaction
        priority if (!stat.is_release) begin
          priority if (stat.slot_free) begin
            cmd.grant_now = 1'b1;
          end else if (stat.q_full) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.enqueue = 1'b1;
          end
        end else begin
          priority if (stat.none_busy) begin
            cmd.ignore = 1'b1;
          end else if (!stat.q_empty) begin
            cmd.grant_head = 1'b1;
          end else begin
            cmd.slot_dec = 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/psa_datapath.sv -----
`default_nettype none

module psa_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psa_pkg::psa_in_t   in_data,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire psa_pkg::psa_cmd_t  cmd,
  output psa_pkg::psa_stat_t      stat,
  output logic                    out_valid,
  output psa_pkg::psa_out_t       out_data
);
  import psa_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  psa_in_t            in_r;
  logic [7:0]         cap_r;
  logic [7:0]         slots_r;
  logic [7:0]         slots_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic signed [15:0] prio_r [QUEUE_DEPTH];
  logic [7:0]         tag_r  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stay;
  logic               out_valid_r;
  psa_out_t           out_r;
  psa_out_t           out_nxt;
  logic [CW+WAIT_W-1:0] count_ext;

  // hold the transaction while the controller works on it
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign stat.is_release = (in_r.req_type == REQ_RELEASE);
  assign stat.slot_free  = (slots_r < cap_r);
  assign stat.q_full     = (count_r == CW'(QUEUE_DEPTH));
  assign stat.q_empty    = (count_r == '0);
  assign stat.none_busy  = (slots_r == 8'd0);

  // a cell keeps its entry if it is occupied and not ranked after the newcomer
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      stay[i] = (CW'(i) < count_r) && (prio_r[i] <= in_r.priority_req);
    end
  end

  // shift-insert row: insert, pop head, or hold
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.enqueue && !stay[i]) begin
        if (i == 0) begin
          prio_r[i] <= in_r.priority_req;
          tag_r[i]  <= in_r.requester_tag;
        end else if (stay[i-1]) begin
          prio_r[i] <= in_r.priority_req;
          tag_r[i]  <= in_r.requester_tag;
        end else begin
          prio_r[i] <= prio_r[i-1];
          tag_r[i]  <= tag_r[i-1];
        end
      end else if (cmd.grant_head && (i < QUEUE_DEPTH - 1)) begin
        prio_r[i] <= prio_r[i+1];
        tag_r[i]  <= tag_r[i+1];
      end
    end
  end

  always_comb begin
    slots_nxt = slots_r;
    count_nxt = count_r;
    if (cmd.grant_now) begin
      slots_nxt = slots_r + 8'd1;
    end
    if (cmd.slot_dec) begin
      slots_nxt = slots_r - 8'd1;
    end
    if (cmd.enqueue) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.grant_head) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= 8'd0;
      count_r <= '0;
    end else if (cmd.exec) begin
      slots_r <= slots_nxt;
      count_r <= count_nxt;
    end
  end

  assign count_ext = {{WAIT_W{1'b0}}, count_nxt};

  always_comb begin
    out_nxt                 = '0;
    out_nxt.grant_valid     = cmd.grant_now | cmd.grant_head;
    out_nxt.queued          = cmd.enqueue;
    out_nxt.rejected        = cmd.reject;
    out_nxt.release_ignored = cmd.ignore;
    out_nxt.busy_count      = slots_nxt;
    out_nxt.waiting_count   = count_ext[WAIT_W-1:0];
    if (cmd.grant_now) begin
      out_nxt.grant_tag = in_r.requester_tag;
    end else if (cmd.grant_head) begin
      out_nxt.grant_tag = tag_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/priority_slot_arbiter_top.sv -----
// Priority slot arbiter: a counting semaphore guarding slot_capacity slots,
// with a sorted wait queue of QUEUE_DEPTH entries. Pulse start with a
// transaction on in_data while busy is low; it is taken at that edge. The
// transaction is latched in the idle state and resolved in the execute state,
// when the counters and the shift-insert queue row update together; its result
// appears on out_data with out_valid high for exactly one cycle after that.
// busy is high during the execute state and low again in the cycle that
// shows the result, so a new start can be taken at the same edge the result
// is taken; a new transaction is not taken while one is still being resolved.
// There is no back-pressure on the result side: sample out_data whenever
// out_valid is high. Write slot_capacity through cfg_we/cfg_wdata only while
// the block is idle; it resets to one.
`default_nettype none

module priority_slot_arbiter_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // transaction input
  input  wire logic             start,
  output logic                  busy,
  input  wire psa_pkg::psa_in_t in_data,
  // result strobe
  output logic                  out_valid,
  output psa_pkg::psa_out_t     out_data,
  // capacity register
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata
);
  import psa_pkg::*;

  psa_cmd_t  cmd;
  psa_stat_t stat;

  // sequence: idle, then an execute state per transaction
  psa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // counters, capacity register, sorted queue row and result register
  psa_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/psa_checker.sv -----
`default_nettype none

module psa_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire psa_pkg::psa_out_t out_data
);
  import psa_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // every accepted transaction yields its result once the execute state has registered it
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing after accepted transaction");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without accepted transaction");

  // block is busy while resolving a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting");

  // at most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_data.grant_valid, out_data.queued,
                               out_data.rejected, out_data.release_ignored}) <= 1))
    else $error("conflicting outcome flags");

  // a queued request leaves the queue non-empty
  a_queued_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.queued) |-> (out_data.waiting_count != '0))
    else $error("queued with empty queue");

endmodule

bind priority_slot_arbiter_top psa_checker u_psa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
